/* rtl/core/knps_pkg.sv */
// ============================================================================
// knps_pkg - shared types and codes for the k-nearest point selector
// Beat layouts of both channels, slot contents, register indexes and the
// controller state encoding.
// ============================================================================
package knps_pkg;

  localparam int COORD_W = 16;
  localparam int ID_W    = 16;
  localparam int DIST_W  = 33;
  localparam int KCFG_W  = 5;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_K_USED  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [ID_W-1:0]           point_id;
    logic                      last_point;
  } knps_in_t;

  typedef struct packed {
    logic [ID_W-1:0]   neighbour_id;
    logic [DIST_W-1:0] neighbour_distance;
    logic              last_result;
  } knps_out_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
  } knps_slot_t;

  // per-cell control
  typedef struct packed {
    logic shift;
    logic wr;
  } knps_cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_DECIDE,
    S_SCAN,
    S_EMIT
  } knps_state_t;

endpackage

/* rtl/core/knps_dist.sv */
// ============================================================================
// knps_dist - squared distance datapath
// Two registered stages: coordinate difference magnitudes, then squares.
// The sum of the two squares is presented combinationally.
// ============================================================================
module knps_dist
  import knps_pkg::*;
(
  input  logic                      clk,
  input  logic                      ld_diff,
  input  logic                      ld_square,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] query_x,
  input  logic signed [COORD_W-1:0] query_y,
  output logic [DIST_W-1:0]         sq_dist
);

  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]          mag_x, mag_y;
  logic [COORD_W-1:0]        mag_x_r, mag_y_r;
  logic [2*COORD_W-1:0]      sq_x_r, sq_y_r;

  always_comb begin
    dx    = {point_x[COORD_W-1], point_x} - {query_x[COORD_W-1], query_x};
    dy    = {point_y[COORD_W-1], point_y} - {query_y[COORD_W-1], query_y};
    mag_x = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
    mag_y = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
  end

  always_ff @(posedge clk) begin
    if (ld_diff) begin
      mag_x_r <= mag_x[COORD_W-1:0];
      mag_y_r <= mag_y[COORD_W-1:0];
    end
    if (ld_square) begin
      sq_x_r <= mag_x_r * mag_x_r;
      sq_y_r <= mag_y_r * mag_y_r;
    end
  end

  assign sq_dist = DIST_W'(sq_x_r) + DIST_W'(sq_y_r);

endmodule

/* rtl/core/knps_cell.sv */
// ============================================================================
// knps_cell - one neighbour slot of the ring
// Holds one id and distance; loads a new entry or takes its neighbour's entry.
// ============================================================================
module knps_cell
  import knps_pkg::*;
(
  input  logic            clk,
  input  knps_cell_ctrl_t ctrl,
  input  knps_slot_t      wr_data,
  input  knps_slot_t      shift_in,
  output knps_slot_t      q
);

  knps_slot_t slot_r;
  knps_slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.wr) begin
      slot_nxt = wr_data;
    end else if (ctrl.shift) begin
      slot_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign q = slot_r;

endmodule

/* rtl/core/k_nearest_point_selector_unit.sv */
// ============================================================================
// k_nearest_point_selector_unit - brute-force k nearest neighbour selection
// Keeps the k nearest candidates to a configured query point in a ring of
// slot cells and emits them in slot order on the final candidate.
// ============================================================================
// Usage:
//   Write query_x, query_y and k_used through the cfg_ port while idle.
//   Present a candidate beat on in_item and raise start; it is taken at an
//   edge where start is high and busy is low.
//   Each candidate passes the difference, square and decide steps in turn.
//   When it enters a slot, the farthest slot is found again by rotating
//   the ring of K_MAX cells once past the head compare.
//   A candidate with last_point set skips that search and rotates the ring
//   once for output instead, with one result beat per filled slot, in
//   slot order, on consecutive cycles. out_strobe marks each beat for
//   exactly one cycle; the receiver cannot stall it. last_result flags
//   the final beat.
//   After the last beat the fill count clears, ready for the next query.
//   Reset (synchronous, rst_n low) returns to idle with no slots filled,
//   query (0, 0) and k_used 1. Slot contents are not cleared; only filled
//   slots are ever read.
// ============================================================================
module k_nearest_point_selector_unit
  import knps_pkg::*;
#(
  parameter int K_MAX = 16
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  knps_in_t             in_item,
  output logic                 out_strobe,
  output knps_out_t            out_result,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  // slot index and fill count widths follow the slot count
  localparam int SW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CW = $clog2(K_MAX + 1);

  // configuration registers
  logic signed [COORD_W-1:0] cfg_query_x_r;
  logic signed [COORD_W-1:0] cfg_query_y_r;
  logic [KCFG_W-1:0]         cfg_k_used_r;

  // controller state
  knps_state_t       state_r, state_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [DIST_W-1:0] far_dist_r, far_dist_nxt;
  logic [SW-1:0]     far_slot_r, far_slot_nxt;
  logic              last_r;
  logic [ID_W-1:0]   id_r;
  logic              out_strobe_r, out_strobe_nxt;
  knps_out_t         out_result_r;

  // decoded controls
  logic              ld_diff, ld_square, cell_wr, ring_shift;
  logic [DIST_W-1:0] cand_dist;
  logic [CW-1:0]     k_eff;
  logic              do_fill, do_replace, do_insert;
  logic              step_done, step_in_fill;
  logic [SW-1:0]     wr_idx;
  knps_slot_t        wr_slot;
  knps_slot_t        cell_q [K_MAX];

  assign busy = (state_r != S_IDLE);

  // --------------------------------------------------------------------------
  // Configuration port: plain writes, unknown indexes dropped
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_query_x_r <= '0;
      cfg_query_y_r <= '0;
      cfg_k_used_r  <= KCFG_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_QUERY_X: cfg_query_x_r <= cfg_wdata;
        CFG_QUERY_Y: cfg_query_y_r <= cfg_wdata;
        CFG_K_USED:  cfg_k_used_r  <= cfg_wdata[KCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp k to 1..K_MAX
  always_comb begin
    if (cfg_k_used_r == '0) begin
      k_eff = CW'(1);
    end else if (int'(cfg_k_used_r) > K_MAX) begin
      k_eff = CW'(K_MAX);
    end else begin
      k_eff = CW'(cfg_k_used_r);
    end
  end

  // --------------------------------------------------------------------------
  // Distance datapath
  // --------------------------------------------------------------------------
  knps_dist u_dist (
    .clk       (clk),
    .ld_diff   (ld_diff),
    .ld_square (ld_square),
    .point_x   (in_item.point_x),
    .point_y   (in_item.point_y),
    .query_x   (cfg_query_x_r),
    .query_y   (cfg_query_y_r),
    .sq_dist   (cand_dist)
  );

  // hold id and last flag of the beat in flight
  always_ff @(posedge clk) begin
    if (ld_diff) begin
      id_r <= in_item.point_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= 1'b0;
    end else if (ld_diff) begin
      last_r <= in_item.last_point;
    end
  end

  // --------------------------------------------------------------------------
  // Insert decision: fill the next free slot, else replace the farthest one
  // when strictly nearer
  // --------------------------------------------------------------------------
  always_comb begin
    do_fill    = (fill_r < k_eff);
    do_replace = !do_fill && (cand_dist < far_dist_r);
    do_insert  = do_fill || do_replace;
    wr_idx     = do_fill ? fill_r[SW-1:0] : far_slot_r;
    wr_slot.id       = id_r;
    wr_slot.distance = cand_dist;
  end

  // --------------------------------------------------------------------------
  // Ring of slot cells. Cell i takes from cell i+1, so the head (cell 0)
  // shows slot j after j shifts; a full turn of K_MAX shifts restores order.
  // Writes only happen with the ring at rest.
  // --------------------------------------------------------------------------
  for (genvar gi = 0; gi < K_MAX; gi++) begin : g_cell
    knps_cell_ctrl_t ctrl;
    always_comb begin
      ctrl.shift = ring_shift;
      ctrl.wr    = cell_wr && (wr_idx == SW'(gi));
    end
    knps_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .wr_data  (wr_slot),
      .shift_in (cell_q[(gi + 1) % K_MAX]),
      .q        (cell_q[gi])
    );
  end

  assign step_done    = (step_r == SW'(K_MAX - 1));
  assign step_in_fill = (CW'(step_r) < fill_r);

  // --------------------------------------------------------------------------
  // Controller: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SQUARE;
      end
      S_SQUARE: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (last_r) begin
          state_nxt = S_EMIT;
        end else if (do_insert) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (step_done) state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (step_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    ld_diff    = 1'b0;
    ld_square  = 1'b0;
    cell_wr    = 1'b0;
    ring_shift = 1'b0;
    unique case (state_r)
      S_IDLE:   ld_diff    = start;
      S_SQUARE: ld_square  = 1'b1;
      S_DECIDE: cell_wr    = do_insert;
      S_SCAN:   ring_shift = 1'b1;
      S_EMIT:   ring_shift = 1'b1;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Fill count, farthest tracking, step counter and result strobe
  // --------------------------------------------------------------------------
  always_comb begin
    fill_nxt       = fill_r;
    far_dist_nxt   = far_dist_r;
    far_slot_nxt   = far_slot_r;
    step_nxt       = '0;
    out_strobe_nxt = 1'b0;
    case (state_r)
      S_DECIDE: begin
        if (do_fill) fill_nxt = fill_r + CW'(1);
        // restart the farthest search after any insert
        if (do_insert) begin
          far_dist_nxt = '0;
          far_slot_nxt = '0;
        end
      end
      S_SCAN: begin
        step_nxt = step_done ? '0 : step_r + SW'(1);
        // strictly greater keeps the lowest index on ties
        if (step_in_fill && (cell_q[0].distance > far_dist_r)) begin
          far_dist_nxt = cell_q[0].distance;
          far_slot_nxt = step_r;
        end
      end
      S_EMIT: begin
        step_nxt       = step_done ? '0 : step_r + SW'(1);
        out_strobe_nxt = step_in_fill;
        if (step_done) begin
          fill_nxt     = '0;
          far_dist_nxt = '0;
          far_slot_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      fill_r       <= '0;
      far_dist_r   <= '0;
      far_slot_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      fill_r       <= fill_nxt;
      far_dist_r   <= far_dist_nxt;
      far_slot_r   <= far_slot_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // result payload: head of the ring during output
  always_ff @(posedge clk) begin
    if (state_r == S_EMIT) begin
      out_result_r.neighbour_id       <= cell_q[0].id;
      out_result_r.neighbour_distance <= cell_q[0].distance;
      out_result_r.last_result        <= (CW'(step_r) == fill_r - CW'(1));
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

`ifndef SYNTHESIS
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == S_EMIT))
    else $error("result beat outside output phase");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(K_MAX) >= fill_r)
    else $error("fill count beyond slot count");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_SQUARE))
    else $error("accepted beat not taken up");

  a_fill_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r == S_EMIT) && state_r == S_IDLE) |-> (fill_r == '0))
    else $error("fill count not cleared after output");

  a_ring_at_rest_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    cell_wr |-> (step_r == '0 && !ring_shift))
    else $error("slot written while ring rotated");
`endif

endmodule
